// ===== rtl/core/tla_pkg.sv =====
// Package for the telnet line assembler: command, result and telnet codes,
// phase codes and the per-item result descriptor. No dependencies.
package tla_pkg;

  // Input commands
  localparam logic [2:0] CMD_RX       = 3'd0;
  localparam logic [2:0] CMD_READ     = 3'd1;
  localparam logic [2:0] CMD_PASS_ON  = 3'd2;
  localparam logic [2:0] CMD_PASS_OFF = 3'd3;
  localparam logic [2:0] CMD_RELEASE  = 3'd4;

  // Result kinds
  localparam logic [2:0] K_ACCEPTED = 3'd0;
  localparam logic [2:0] K_SEND     = 3'd1;
  localparam logic [2:0] K_LINE     = 3'd2;
  localparam logic [2:0] K_READ     = 3'd3;
  localparam logic [2:0] K_PENDING  = 3'd4;
  localparam logic [2:0] K_CLOSED   = 3'd5;
  localparam logic [2:0] K_INTR     = 3'd6;
  localparam logic [2:0] K_FLOOD    = 3'd7;

  // Byte codes
  localparam logic [7:0] C_BS       = 8'd8;
  localparam logic [7:0] C_LF       = 8'd10;
  localparam logic [7:0] C_CR       = 8'd13;
  localparam logic [7:0] C_SPACE    = 8'd32;
  localparam logic [7:0] C_TILDE    = 8'd126;
  localparam logic [7:0] C_DEL      = 8'd127;
  localparam logic [7:0] C_OPT_ECHO = 8'd1;
  localparam logic [7:0] C_OPT_EOR  = 8'd25;
  localparam logic [7:0] C_IP       = 8'd244;
  localparam logic [7:0] C_EC       = 8'd247;
  localparam logic [7:0] C_EL       = 8'd248;
  localparam logic [7:0] C_WILL     = 8'd251;
  localparam logic [7:0] C_WONT     = 8'd252;
  localparam logic [7:0] C_DO       = 8'd253;
  localparam logic [7:0] C_DONT     = 8'd254;
  localparam logic [7:0] C_IAC      = 8'd255;

  // Telnet receive phase
  localparam logic [1:0] PH_DATA = 2'd0;
  localparam logic [1:0] PH_IAC  = 2'd1;
  localparam logic [1:0] PH_DO   = 2'd2;
  localparam logic [1:0] PH_DONT = 2'd3;

  // Echo flag bit positions
  localparam int unsigned F_ECHO = 0;
  localparam int unsigned F_PASS = 1;
  localparam int unsigned F_EOR  = 2;
  localparam int unsigned F_GA   = 3;

  localparam logic [8:0] JUNK_MAX = 9'd511;
  localparam logic [7:0] FLOOD_RESET = 8'd100;

  // Config register indexes
  localparam logic CFG_GA    = 1'b0;
  localparam logic CFG_FLOOD = 1'b1;

  // Results of one input item; cnt is 1 to 3. is_read takes the value of
  // the single result from the line store read port.
  typedef struct packed {
    logic [1:0]      cnt;
    logic            is_read;
    logic [2:0][2:0] kind;
    logic [2:0][7:0] value;
  } res_desc_t;

endpackage

// ===== rtl/core/telnet_line_assembler_core.sv =====
// Telnet line assembler top level: control unit, line store RAM and the
// result output stage. Depends on tla_pkg, tla_ctrl and tla_ram.
//
//  channel   | dir | tdata               | tuser      | tlast
//  s_axis    | in  | rx_byte, read_index | command    | -
//  m_axis    | out | value               | kind       | last
//  cfg       | in  | cfg_data_i (8 bits) via cfg_we_i / cfg_index_i
//
// An item's first result is valid the cycle after accept; one-result items
// follow back to back while the output is taken. Two or three results hold
// the single result register until the last one is taken. A line store read
// takes its data from the RAM read register. Reset clears all session state;
// the line store needs no clearing. s_axis_tready stays low while the result
// register holds an item, until its last result is taken.
module telnet_line_assembler_core #(
  parameter int unsigned LINE_STORE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] rx_byte, [15:8] read_index
  input  logic [2:0]  s_axis_tuser,  // [2:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] value
  output logic [2:0]  m_axis_tuser,  // [2:0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  import tla_pkg::*;

  localparam int unsigned PW = $clog2(LINE_STORE_DEPTH);

  logic          accept;
  logic          out_free;
  logic          out_last;
  res_desc_t     desc;
  res_desc_t     desc_q;
  logic          out_valid_q;
  logic [1:0]    idx_q;
  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [PW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  tla_ctrl #(
    .LINE_STORE_DEPTH(LINE_STORE_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .command_i    (s_axis_tuser),
    .rx_byte_i    (s_axis_tdata[7:0]),
    .read_index_i (s_axis_tdata[15:8]),
    .desc_o       (desc),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr)
  );

  tla_ram #(
    .WIDTH(8),
    .DEPTH(LINE_STORE_DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_last      = (idx_q == desc_q.cnt - 2'd1);
  assign out_free      = !out_valid_q || (m_axis_tready && out_last);
  assign s_axis_tready = out_free;
  assign accept        = s_axis_tvalid && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (out_valid_q && m_axis_tready) begin
      // advance to the next result, drop the item after its last one
      if (out_last) out_valid_q <= 1'b0;
      else idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      desc_q <= desc;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = desc_q.kind[idx_q];
  assign m_axis_tdata  = desc_q.is_read ? ram_rdata : desc_q.value[idx_q];
  assign m_axis_tlast  = out_last;

endmodule

// ===== rtl/core/tla_ram.sv =====
// Generic single-clock RAM, one write port and one read port with a
// registered, enable-held read output. No dependencies.
module tla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tla_ctrl.sv =====
// Line discipline control: session state registers, config registers and the
// per-item decision. Drives the line store ports. Depends on tla_pkg.
module tla_ctrl #(
  parameter int unsigned LINE_STORE_DEPTH = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_index_i,
  input  logic [7:0]                          cfg_data_i,
  input  logic                                accept_i,
  input  logic [2:0]                          command_i,
  input  logic [7:0]                          rx_byte_i,
  input  logic [7:0]                          read_index_i,
  output tla_pkg::res_desc_t                  desc_o,
  output logic                                ram_we_o,
  output logic [$clog2(LINE_STORE_DEPTH)-1:0] ram_waddr_o,
  output logic [7:0]                          ram_wdata_o,
  output logic                                ram_re_o,
  output logic [$clog2(LINE_STORE_DEPTH)-1:0] ram_raddr_o
);

  import tla_pkg::*;

  localparam int unsigned PW = $clog2(LINE_STORE_DEPTH);
  localparam logic [PW-1:0] WP_LIMIT = PW'(LINE_STORE_DEPTH - 3);

  logic [PW-1:0] wp_q, wp_d;
  logic [PW-1:0] len_q, len_d;
  logic          pending_q, pending_d;
  logic          cr_q, cr_d;
  logic          lf_q, lf_d;
  logic [1:0]    phase_q, phase_d;
  logic [3:0]    flags_q, flags_d;
  logic [8:0]    junk_q, junk_d;
  logic          closed_q, closed_d;
  logic          ga_cfg_q;
  logic [7:0]    flood_q;

  logic          in_range;
  logic [8:0]    junk_inc;
  res_desc_t     desc;

  assign in_range = read_index_i < 8'(len_q);
  assign junk_inc = (junk_q == JUNK_MAX) ? junk_q : junk_q + 9'd1;

  always_comb begin
    wp_d      = wp_q;
    len_d     = len_q;
    pending_d = pending_q;
    cr_d      = cr_q;
    lf_d      = lf_q;
    phase_d   = phase_q;
    flags_d   = flags_q;
    junk_d    = junk_q;
    closed_d  = closed_q;

    desc         = '0;
    desc.cnt     = 2'd1;
    ram_we_o     = 1'b0;
    ram_waddr_o  = wp_q;
    ram_wdata_o  = 8'd0;
    ram_re_o     = 1'b0;
    ram_raddr_o  = read_index_i[PW-1:0];

    case (command_i) inside
      CMD_READ: begin
        desc.kind[0] = K_READ;
        desc.is_read = in_range;
        ram_re_o     = accept_i && in_range;
      end
      CMD_RX, CMD_PASS_ON, CMD_PASS_OFF, CMD_RELEASE: begin
        if (closed_q) begin
          desc.kind[0] = K_CLOSED;
        end else if (command_i == CMD_RX) begin
          if (pending_q) begin
            desc.kind[0] = K_PENDING;
          end else begin
            unique case (phase_q)
              PH_IAC: begin
                phase_d = PH_DATA;
                if (rx_byte_i == C_EC) begin
                  ram_we_o = 1'b1;
                  if (wp_q != '0) wp_d = wp_q - 1'b1;
                end else if (rx_byte_i == C_EL) begin
                  wp_d = '0;
                end else if (rx_byte_i == C_IP) begin
                  closed_d     = 1'b1;
                  desc.kind[0] = K_INTR;
                end else if (rx_byte_i == C_DO) begin
                  phase_d = PH_DO;
                end else if (rx_byte_i == C_DONT) begin
                  phase_d = PH_DONT;
                end
              end
              PH_DO: begin
                phase_d = PH_DATA;
                if (rx_byte_i == C_OPT_ECHO) begin
                  if (!flags_q[F_PASS]) flags_d[F_ECHO] = 1'b1;
                end else if (rx_byte_i == C_OPT_EOR) begin
                  flags_d[F_EOR] = 1'b1;
                  flags_d[F_GA]  = 1'b0;
                  desc.cnt       = 2'd2;
                  desc.kind[0]   = K_SEND;
                  desc.value[0]  = C_IAC;
                  desc.kind[1]   = K_SEND;
                  desc.value[1]  = C_OPT_EOR;
                end
              end
              PH_DONT: begin
                phase_d = PH_DATA;
                if (rx_byte_i == C_OPT_ECHO) begin
                  flags_d[F_ECHO] = 1'b0;
                end else if (rx_byte_i == C_OPT_EOR) begin
                  flags_d[F_EOR] = 1'b0;
                  if (ga_cfg_q) flags_d[F_GA] = 1'b1;
                end
              end
              default: begin
                if (rx_byte_i == C_IAC) begin
                  cr_d    = 1'b0;
                  lf_d    = 1'b0;
                  phase_d = PH_IAC;
                end else if (rx_byte_i == C_LF || rx_byte_i == C_CR) begin
                  // a LF after CR (or CR after LF) is swallowed, flags kept
                  if ((rx_byte_i == C_LF && !cr_q) || (rx_byte_i == C_CR && !lf_q)) begin
                    if (rx_byte_i == C_LF) lf_d = 1'b1;
                    else cr_d = 1'b1;
                    junk_d        = '0;
                    pending_d     = 1'b1;
                    len_d         = wp_q;
                    wp_d          = '0;
                    desc.kind[0]  = K_LINE;
                    desc.value[0] = 8'(wp_q);
                  end
                end else begin
                  cr_d = 1'b0;
                  lf_d = 1'b0;
                  if (rx_byte_i == C_BS || rx_byte_i == C_DEL || rx_byte_i == C_EC) begin
                    ram_we_o = 1'b1;
                    if (wp_q != '0) wp_d = wp_q - 1'b1;
                  end else if (rx_byte_i >= C_SPACE && rx_byte_i <= C_TILDE &&
                               wp_q < WP_LIMIT) begin
                    ram_we_o    = 1'b1;
                    ram_wdata_o = rx_byte_i;
                    wp_d        = wp_q + 1'b1;
                    if (!flags_q[F_PASS] && flags_q[F_ECHO]) begin
                      desc.kind[0]  = K_SEND;
                      desc.value[0] = rx_byte_i;
                    end
                  end else begin
                    junk_d = junk_inc;
                    if (junk_inc > {1'b0, flood_q}) begin
                      closed_d     = 1'b1;
                      desc.kind[0] = K_FLOOD;
                    end
                  end
                end
              end
            endcase
          end
        end else if (command_i == CMD_RELEASE) begin
          pending_d = 1'b0;
        end else begin
          flags_d[F_PASS] = (command_i == CMD_PASS_ON);
          if (!flags_q[F_ECHO]) begin
            desc.cnt      = 2'd3;
            desc.kind[0]  = K_SEND;
            desc.value[0] = C_IAC;
            desc.kind[1]  = K_SEND;
            desc.value[1] = (command_i == CMD_PASS_ON) ? C_WILL : C_WONT;
            desc.kind[2]  = K_SEND;
            desc.value[2] = C_OPT_ECHO;
          end
        end
      end
      default: begin
        desc.kind[0] = K_ACCEPTED;
      end
    endcase

    // memory writes only happen on an accepted item
    ram_we_o = ram_we_o && accept_i;
  end

  assign desc_o = desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      len_q     <= '0;
      pending_q <= 1'b0;
      cr_q      <= 1'b0;
      lf_q      <= 1'b0;
      phase_q   <= PH_DATA;
      flags_q   <= '0;
      junk_q    <= '0;
      closed_q  <= 1'b0;
    end else if (accept_i) begin
      wp_q      <= wp_d;
      len_q     <= len_d;
      pending_q <= pending_d;
      cr_q      <= cr_d;
      lf_q      <= lf_d;
      phase_q   <= phase_d;
      flags_q   <= flags_d;
      junk_q    <= junk_d;
      closed_q  <= closed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ga_cfg_q <= 1'b0;
      flood_q  <= FLOOD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GA:    ga_cfg_q <= cfg_data_i[0];
        CFG_FLOOD: flood_q  <= cfg_data_i;
        default:   ;
      endcase
    end
  end

endmodule
